// ----- hdl/fac_pkg.sv -----
package fac_pkg;

	localparam int MAX_BLOCKS_DEF   = 64;
	localparam int HEADER_BYTES_DEF = 32;
	localparam int OFFSET_BITS_DEF  = 24;
	localparam int FIELD_W          = 24;
	localparam logic [FIELD_W-1:0] RESET_HEAP = 24'd65536;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_NO_FIT   = 2'd1;
	localparam logic [1:0] STAT_FULL     = 2'd2;
	localparam logic [1:0] STAT_BAD_FREE = 2'd3;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef struct packed {
		logic               op;
		logic [FIELD_W-1:0] request_bytes;
		logic [FIELD_W-1:0] release_offset;
	} req_t;

	typedef struct packed {
		logic [FIELD_W-1:0] payload_offset;
		logic [1:0]         status;
	} rsp_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SRCH,
		S_APPLY,
		S_OUT
	} state_t;

	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_INIT,
		CMD_ALLOC,
		CMD_FREE_BOTH,
		CMD_FREE_PREV,
		CMD_FREE_NEXT,
		CMD_FREE_SOLO
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [FIELD_W-1:0] req;
		logic [FIELD_W-1:0] rel;
	} cmd_t;

	typedef struct packed {
		logic own;
		logic left;
		logic right;
		logic bef;
	} sel_t;

endpackage

// ----- hdl/fac_cell.sv -----
module fac_cell #(
	parameter int HEADER_BYTES = fac_pkg::HEADER_BYTES_DEF,
	parameter int OFFSET_BITS  = fac_pkg::OFFSET_BITS_DEF,
	parameter bit FIRST        = 1'b0
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  fac_pkg::cmd_t          cmd,
	input  fac_pkg::sel_t          sel,
	input  logic [OFFSET_BITS-1:0] init_size,
	input  logic                   lv,
	input  logic                   lf,
	input  logic [OFFSET_BITS-1:0] loff,
	input  logic [OFFSET_BITS-1:0] lsize,
	input  logic                   rv,
	input  logic                   rf,
	input  logic [OFFSET_BITS-1:0] roff,
	input  logic [OFFSET_BITS-1:0] rsize,
	input  logic                   rrv,
	input  logic                   rrf,
	input  logic [OFFSET_BITS-1:0] rroff,
	input  logic [OFFSET_BITS-1:0] rrsize,
	output logic                   v,
	output logic                   f,
	output logic [OFFSET_BITS-1:0] off,
	output logic [OFFSET_BITS-1:0] size,
	output logic                   fit,
	output logic                   hit,
	output logic [fac_pkg::FIELD_W-1:0] pofs
);
	import fac_pkg::*;

	localparam int MW = (OFFSET_BITS > FIELD_W) ? OFFSET_BITS : FIELD_W;
	localparam int NW = MW + 10;
	localparam logic [NW-1:0] HDR = NW'(HEADER_BYTES);
	localparam logic [OFFSET_BITS-1:0] RST_SIZE =
		(NW'(RESET_HEAP) >= HDR) ? OFFSET_BITS'(NW'(RESET_HEAP) - HDR) : '0;

	logic                   v_q, f_q;
	logic [OFFSET_BITS-1:0] off_q, size_q;
	logic                   v_d, f_d;
	logic [OFFSET_BITS-1:0] off_d, size_d;
	logic [NW-1:0]          req_x, need_x, size_x, poff_x;

	assign req_x  = NW'(cmd.req);
	assign need_x = req_x + HDR;
	assign size_x = NW'(size_q);
	assign poff_x = NW'(off_q) + HDR;

	assign fit  = v_q & f_q & (size_x >= need_x);
	assign hit  = v_q & ~f_q & (NW'(poff_x[OFFSET_BITS-1:0]) == NW'(cmd.rel));
	assign pofs = poff_x[FIELD_W-1:0];

	always_comb begin
		v_d    = v_q;
		f_d    = f_q;
		off_d  = off_q;
		size_d = size_q;
		case (cmd.kind)
			CMD_INIT: begin
				v_d    = FIRST;
				f_d    = FIRST;
				off_d  = '0;
				size_d = init_size;
			end
			CMD_ALLOC: begin
				if (sel.own) begin
					size_d = OFFSET_BITS'(req_x);
					f_d    = 1'b0;
				end else if (sel.left) begin
					v_d    = 1'b1;
					f_d    = 1'b1;
					off_d  = OFFSET_BITS'(NW'(loff) + need_x);
					size_d = OFFSET_BITS'(NW'(lsize) - need_x);
				end else if (sel.bef) begin
					v_d = lv; f_d = lf; off_d = loff; size_d = lsize;
				end
			end
			CMD_FREE_BOTH: begin
				if (sel.right) begin
					size_d = OFFSET_BITS'(size_x + NW'(rsize) + NW'(rrsize) + HDR + HDR);
				end else if (sel.bef | sel.own) begin
					v_d = rrv; f_d = rrf; off_d = rroff; size_d = rrsize;
				end
			end
			CMD_FREE_PREV: begin
				if (sel.right) begin
					size_d = OFFSET_BITS'(size_x + NW'(rsize) + HDR);
				end else if (sel.bef | sel.own) begin
					v_d = rv; f_d = rf; off_d = roff; size_d = rsize;
				end
			end
			CMD_FREE_NEXT: begin
				if (sel.own) begin
					size_d = OFFSET_BITS'(size_x + NW'(rsize) + HDR);
					f_d    = 1'b1;
				end else if (sel.bef) begin
					v_d = rv; f_d = rf; off_d = roff; size_d = rsize;
				end
			end
			CMD_FREE_SOLO: begin
				if (sel.own) begin
					f_d = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q    <= FIRST;
			f_q    <= FIRST;
			off_q  <= '0;
			size_q <= RST_SIZE;
		end else begin
			v_q    <= v_d;
			f_q    <= f_d;
			off_q  <= off_d;
			size_q <= size_d;
		end
	end

	assign v    = v_q;
	assign f    = f_q;
	assign off  = off_q;
	assign size = size_q;

endmodule

// ----- hdl/first_fit_block_allocator_unit.sv -----
// First-fit heap block allocator.
// Request channel (req_valid/req_stall/req_data): op 0 allocates
// request_bytes of payload, op 1 frees the block whose payload starts at
// release_offset. One response beat per request on rsp_valid/rsp_stall/
// rsp_data: granted payload offset (zero on failure or free) and a status.
// Config channel (cfg_valid/cfg_ready/cfg_data) writes the heap size and
// rebuilds the table as one free block; write only while idle.
// Blocks live in a row of cells, one per table entry, address ordered.
// A request beat passes through search, update and output states before
// response valid; one request in flight, the next taken after the response.
// The search and the shifting insert/merge each work over the whole row;
// neighbors hand entries along the row when one is added or removed.
// Reset: table holds one free block spanning a 65536 byte heap.
// While the response is stalled the unit holds it and takes no request.
module first_fit_block_allocator_unit #(
	parameter int MAX_BLOCKS   = fac_pkg::MAX_BLOCKS_DEF,
	parameter int HEADER_BYTES = fac_pkg::HEADER_BYTES_DEF,
	parameter int OFFSET_BITS  = fac_pkg::OFFSET_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  fac_pkg::req_t req_data,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output fac_pkg::rsp_t rsp_data,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [fac_pkg::FIELD_W-1:0] cfg_data
);
	import fac_pkg::*;

	localparam int N  = MAX_BLOCKS;
	localparam int MW = (OFFSET_BITS > FIELD_W) ? OFFSET_BITS : FIELD_W;
	localparam int NW = MW + 10;
	localparam logic [NW-1:0] HDR = NW'(HEADER_BYTES);

	state_t state_q, state_d;
	req_t   req_q;
	rsp_t   rsp_q, rsp_d;
	cmd_t   cmd;
	logic   accept, load_rsp;

	logic                   v   [0:N+1];
	logic                   f   [0:N+1];
	logic [OFFSET_BITS-1:0] off [0:N+1];
	logic [OFFSET_BITS-1:0] sz  [0:N+1];
	logic [N-1:0]           fit, hit, match, sel_c, sel_s1, bef;
	logic [N:0]             pre;
	logic [FIELD_W-1:0]     pofs [0:N-1];
	logic                   found_s1, full_s1, op_s1;
	logic [OFFSET_BITS-1:0] init_size;
	logic [NW-1:0]          heap_x;
	logic                   pf, nf;
	logic [FIELD_W-1:0]     ofs_sel;

	assign v[N] = 1'b0;   assign f[N] = 1'b0;   assign off[N] = '0;   assign sz[N] = '0;
	assign v[N+1] = 1'b0; assign f[N+1] = 1'b0; assign off[N+1] = '0; assign sz[N+1] = '0;

	assign heap_x    = NW'(cfg_data);
	assign init_size = (heap_x >= HDR) ? OFFSET_BITS'(heap_x - HDR) : '0;

	assign match = (req_q.op == OP_FREE) ? hit : fit;
	assign pre[0] = 1'b0;
	assign bef[0] = 1'b0;
	genvar j;
	generate
		for (j = 0; j < N; j++) begin : g_row
			sel_t sj;
			assign sel_c[j]  = match[j] & ~pre[j];
			assign pre[j+1]  = pre[j] | match[j];
			if (j > 0) begin : g_bef
				assign bef[j] = bef[j-1] | sel_s1[j-1];
			end
			assign sj.own   = sel_s1[j];
			assign sj.left  = (j > 0) ? sel_s1[(j > 0) ? j-1 : 0] : 1'b0;
			assign sj.right = (j < N-1) ? sel_s1[(j < N-1) ? j+1 : 0] : 1'b0;
			assign sj.bef   = bef[j];

			if (j == 0) begin : g_first
				fac_cell #(
					.HEADER_BYTES(HEADER_BYTES), .OFFSET_BITS(OFFSET_BITS), .FIRST(1'b1)
				) u_cell (
					.clk(clk), .arst_n(arst_n), .cmd(cmd), .sel(sj), .init_size(init_size),
					.lv(1'b0), .lf(1'b0), .loff('0), .lsize('0),
					.rv(v[j+1]), .rf(f[j+1]), .roff(off[j+1]), .rsize(sz[j+1]),
					.rrv(v[j+2]), .rrf(f[j+2]), .rroff(off[j+2]), .rrsize(sz[j+2]),
					.v(v[j]), .f(f[j]), .off(off[j]), .size(sz[j]),
					.fit(fit[j]), .hit(hit[j]), .pofs(pofs[j])
				);
			end else begin : g_rest
				fac_cell #(
					.HEADER_BYTES(HEADER_BYTES), .OFFSET_BITS(OFFSET_BITS), .FIRST(1'b0)
				) u_cell (
					.clk(clk), .arst_n(arst_n), .cmd(cmd), .sel(sj), .init_size(init_size),
					.lv(v[j-1]), .lf(f[j-1]), .loff(off[j-1]), .lsize(sz[j-1]),
					.rv(v[j+1]), .rf(f[j+1]), .roff(off[j+1]), .rsize(sz[j+1]),
					.rrv(v[j+2]), .rrf(f[j+2]), .rroff(off[j+2]), .rrsize(sz[j+2]),
					.v(v[j]), .f(f[j]), .off(off[j]), .size(sz[j]),
					.fit(fit[j]), .hit(hit[j]), .pofs(pofs[j])
				);
			end
		end
	endgenerate

	always_comb begin
		pf      = 1'b0;
		nf      = 1'b0;
		ofs_sel = '0;
		for (int k = 0; k < N; k++) begin
			if (sel_s1[k]) begin
				pf      = pf | ((k > 0) ? (v[(k > 0) ? k-1 : 0] & f[(k > 0) ? k-1 : 0]) : 1'b0);
				nf      = nf | (v[k+1] & f[k+1]);
				ofs_sel = ofs_sel | pofs[k];
			end
		end
	end

	// command broadcast to the row
	always_comb begin
		cmd.req  = req_q.request_bytes;
		cmd.rel  = req_q.release_offset;
		cmd.kind = CMD_NONE;
		rsp_d.payload_offset = '0;
		rsp_d.status         = STAT_OK;
		if (op_s1 == OP_ALLOC) begin
			if (!found_s1) begin
				rsp_d.status = STAT_NO_FIT;
			end else if (full_s1) begin
				rsp_d.status = STAT_FULL;
			end else begin
				cmd.kind = CMD_ALLOC;
				rsp_d.payload_offset = ofs_sel;
			end
		end else begin
			if (!found_s1) begin
				rsp_d.status = STAT_BAD_FREE;
			end else if (pf && nf) begin
				cmd.kind = CMD_FREE_BOTH;
			end else if (pf) begin
				cmd.kind = CMD_FREE_PREV;
			end else if (nf) begin
				cmd.kind = CMD_FREE_NEXT;
			end else begin
				cmd.kind = CMD_FREE_SOLO;
			end
		end
		if (state_q != S_APPLY) begin
			cmd.kind = CMD_NONE;
		end
		if (cfg_valid) begin
			cmd.kind = CMD_INIT;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (req_valid) state_d = S_SRCH;
			S_SRCH:  state_d = S_APPLY;
			S_APPLY: state_d = S_OUT;
			S_OUT:   if (!rsp_stall) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		req_stall = 1'b1;
		rsp_valid = 1'b0;
		load_rsp  = 1'b0;
		case (state_q)
			S_IDLE:  req_stall = 1'b0;
			S_APPLY: load_rsp  = 1'b1;
			S_OUT:   rsp_valid = 1'b1;
			default: ;
		endcase
	end

	assign accept    = req_valid & ~req_stall;
	assign cfg_ready = 1'b1;
	assign rsp_data  = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req_data;
		end
		if (state_q == S_SRCH) begin
			sel_s1   <= sel_c;
			found_s1 <= pre[N];
			full_s1  <= v[N-1];
			op_s1    <= req_q.op;
		end
		if (load_rsp) begin
			rsp_q <= rsp_d;
		end
	end

endmodule
